/* sv/afc_pkg.sv */
package afc_pkg;

    localparam int TAG_BITS_DEFAULT = 16;

    localparam int NUM_AXES   = 3;
    localparam int NUM_PLANES = 6;

    localparam int COORD_W = 21;
    localparam int COEF_W  = 18;
    localparam int NORM_W  = 12;
    localparam int OFFS_W  = 28;
    localparam int DIST_W  = 22;
    localparam int CAM_W   = NUM_AXES * COORD_W;
    localparam int ROW_W   = NUM_AXES * COEF_W;
    localparam int BOX_W   = 2 * COORD_W;

    localparam int COEF_FRAC   = 14;
    localparam int CAM_SHIFT   = COEF_FRAC + 1;
    localparam int ROUND_SHIFT = COEF_FRAC + 1;
    localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);
    localparam int OFF_SHIFT   = 24;

    localparam int DIF_W = COORD_W + 1;
    localparam int P0_W  = COEF_W + COORD_W;
    localparam int E_W   = COEF_W + DIF_W;
    localparam int C0_W  = P0_W + 2;
    localparam int ES_W  = E_W + 2;
    localparam int D_W   = ES_W + 1;
    localparam int A_W   = D_W - ROUND_SHIFT - 1;
    localparam int SQ_W  = 2 * A_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int NC_W  = NORM_W + C0_W;
    localparam int NE_W  = NORM_W + E_W;
    localparam int DOT_W = NC_W + 2;
    localparam int DE_W  = NE_W + 2;
    localparam int MIN_W = DOT_W + 2;

    localparam int ROOT_W = DIST_W;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 1;

    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = REG_IDX_W + 3;
    localparam int PDATA_W   = 64;

    localparam logic [REG_IDX_W-1:0] REG_CAMERA  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CULL_EN = 3'd7;

    typedef struct packed {
        logic signed [OFFS_W-1:0] offset;
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nx;
    } t_plane;

    typedef struct packed {
        logic valid;
        logic culled;
    } t_item_ctl;

endpackage

/* sv/aabb_frustum_cull_unit.sv */
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    tag, matrix rows, shifts, box extents
// out      output     o_out_valid / i_out_stall  result tag, visible, camera distance
// config   input      APB psel/penable/pwrite    six planes, camera position, culling enable
//
// One transaction is accepted per cycle while o_in_stall is low; its result passes through
// seven arithmetic stages and a 22-stage square root pipeline that resolves one root bit
// per stage. Reset is synchronous and active low; it empties the pipeline and loads zero
// planes, a zero camera position and culling enabled. The output register is backed by
// one skid entry; o_in_stall is high only while that entry is occupied, and the whole
// pipeline holds during that time.
module aabb_frustum_cull_unit #(
    parameter int TAG_BITS = afc_pkg::TAG_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [afc_pkg::PADDR_W-1:0]       paddr,
    input  logic [afc_pkg::PDATA_W-1:0]       pwdata,
    output logic [afc_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [TAG_BITS-1:0]               i_object_tag,
    input  logic [afc_pkg::ROW_W-1:0]         i_matrix_row_x,
    input  logic [afc_pkg::ROW_W-1:0]         i_matrix_row_y,
    input  logic [afc_pkg::ROW_W-1:0]         i_matrix_row_z,
    input  logic signed [afc_pkg::COORD_W-1:0] i_shift_x,
    input  logic signed [afc_pkg::COORD_W-1:0] i_shift_y,
    input  logic signed [afc_pkg::COORD_W-1:0] i_shift_z,
    input  logic [afc_pkg::BOX_W-1:0]         i_box_x,
    input  logic [afc_pkg::BOX_W-1:0]         i_box_y,
    input  logic [afc_pkg::BOX_W-1:0]         i_box_z,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [TAG_BITS-1:0]               o_result_tag,
    output logic                              o_visible,
    output logic [afc_pkg::DIST_W-1:0]        o_camera_distance
);
    import afc_pkg::*;

    t_plane                 r_plane [NUM_PLANES];
    logic [CAM_W-1:0]       r_cam;
    logic                   r_cull_en;
    logic                   w_wr;
    logic [REG_IDX_W-1:0]   w_idx;

    logic signed [NORM_W-1:0]  w_norm [NUM_PLANES][NUM_AXES];
    logic signed [OFFS_W-1:0]  w_offs [NUM_PLANES];
    logic signed [COORD_W-1:0] w_cam  [NUM_AXES];

    logic [ROW_W-1:0]          w_row   [NUM_AXES];
    logic [BOX_W-1:0]          w_box   [NUM_AXES];
    logic signed [COORD_W-1:0] w_shift [NUM_AXES];

    logic w_adv;

    logic                      r1_vld;
    logic [TAG_BITS-1:0]       r1_tag;
    logic signed [COEF_W-1:0]  r1_m   [NUM_AXES][NUM_AXES];
    logic signed [COORD_W-1:0] r1_lo  [NUM_AXES];
    logic signed [DIF_W-1:0]   r1_dif [NUM_AXES];
    logic signed [COORD_W-1:0] r1_sh  [NUM_AXES];

    logic                      r2_vld;
    logic [TAG_BITS-1:0]       r2_tag;
    logic signed [P0_W-1:0]    r2_p0 [NUM_AXES][NUM_AXES];
    logic signed [E_W-1:0]     r2_e  [NUM_AXES][NUM_AXES];
    logic signed [COORD_W-1:0] r2_sh [NUM_AXES];

    logic                      r3_vld;
    logic [TAG_BITS-1:0]       r3_tag;
    logic signed [C0_W-1:0]    r3_c0 [NUM_AXES];
    logic signed [E_W-1:0]     r3_e  [NUM_AXES][NUM_AXES];
    logic signed [ES_W-1:0]    r3_es [NUM_AXES];

    logic                      r4_vld;
    logic [TAG_BITS-1:0]       r4_tag;
    logic signed [NC_W-1:0]    r4_nc [NUM_PLANES][NUM_AXES];
    logic signed [NE_W-1:0]    r4_ne [NUM_PLANES][NUM_AXES][NUM_AXES];
    logic signed [D_W-1:0]     r4_d  [NUM_AXES];

    logic                      r5_vld;
    logic [TAG_BITS-1:0]       r5_tag;
    logic signed [DOT_W-1:0]   r5_dot [NUM_PLANES];
    logic signed [DE_W-1:0]    r5_de  [NUM_PLANES][NUM_AXES];
    logic [A_W-1:0]            r5_a   [NUM_AXES];
    logic [A_W-1:0]            w_a    [NUM_AXES];

    logic                      r6_vld;
    logic [TAG_BITS-1:0]       r6_tag;
    logic signed [MIN_W-1:0]   r6_min [NUM_PLANES];
    logic [SQ_W-1:0]           r6_sq  [NUM_AXES];
    logic signed [MIN_W-1:0]   w_min  [NUM_PLANES];

    logic                      r7_vld;
    logic [TAG_BITS-1:0]       r7_tag;
    logic                      r7_culled;
    logic [SUM_W-1:0]          r7_sum;
    logic [NUM_PLANES-1:0]     w_out;

    t_item_ctl                 w_sq_ctl_in;
    t_item_ctl                 w_last_ctl;
    logic [TAG_BITS-1:0]       w_last_tag;
    logic [DIST_W-1:0]         w_last_dist;

    logic                      r_out_vld;
    logic [TAG_BITS-1:0]       r_out_tag;
    logic                      r_out_vis;
    logic [DIST_W-1:0]         r_out_dist;
    logic                      r_skid_vld;
    logic [TAG_BITS-1:0]       r_skid_tag;
    logic                      r_skid_vis;
    logic [DIST_W-1:0]         r_skid_dist;
    logic                      w_take;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[PADDR_W-1 -: REG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_plane[p] <= '0;
            end
            r_cam     <= '0;
            r_cull_en <= 1'b1;
        end else if (w_wr) begin
            priority if (w_idx == REG_CAMERA) begin
                r_cam <= pwdata[CAM_W-1:0];
            end else if (w_idx == REG_CULL_EN) begin
                r_cull_en <= pwdata[0];
            end else begin
                r_plane[w_idx] <= t_plane'(pwdata);
            end
        end
    end

    always_comb begin
        priority if (w_idx == REG_CAMERA) begin
            prdata = {{(PDATA_W - CAM_W){1'b0}}, r_cam};
        end else if (w_idx == REG_CULL_EN) begin
            prdata = {{(PDATA_W - 1){1'b0}}, r_cull_en};
        end else begin
            prdata = r_plane[w_idx];
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            w_norm[p][0] = $signed(r_plane[p].nx);
            w_norm[p][1] = $signed(r_plane[p].ny);
            w_norm[p][2] = $signed(r_plane[p].nz);
            w_offs[p]    = $signed(r_plane[p].offset);
        end
        for (int r = 0; r < NUM_AXES; r++) begin
            w_cam[r] = $signed(r_cam[r*COORD_W +: COORD_W]);
        end
    end

    always_comb begin
        w_row[0]   = i_matrix_row_x;
        w_row[1]   = i_matrix_row_y;
        w_row[2]   = i_matrix_row_z;
        w_box[0]   = i_box_x;
        w_box[1]   = i_box_y;
        w_box[2]   = i_box_z;
        w_shift[0] = i_shift_x;
        w_shift[1] = i_shift_y;
        w_shift[2] = i_shift_z;
    end

    assign w_adv      = !r_skid_vld;
    assign o_in_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_in_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_tag <= i_object_tag;
            for (int r = 0; r < NUM_AXES; r++) begin
                r1_sh[r]  <= w_shift[r];
                r1_lo[r]  <= $signed(w_box[r][COORD_W-1:0]);
                r1_dif[r] <= DIF_W'($signed(w_box[r][BOX_W-1:COORD_W]))
                           - DIF_W'($signed(w_box[r][COORD_W-1:0]));
                for (int c = 0; c < NUM_AXES; c++) begin
                    r1_m[r][c] <= $signed(w_row[r][c*COEF_W +: COEF_W]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_tag <= r1_tag;
            for (int r = 0; r < NUM_AXES; r++) begin
                r2_sh[r] <= r1_sh[r];
                for (int c = 0; c < NUM_AXES; c++) begin
                    r2_p0[r][c] <= P0_W'(r1_m[r][c]) * P0_W'(r1_lo[c]);
                    r2_e[r][c]  <= E_W'(r1_m[r][c]) * E_W'(r1_dif[c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_tag <= r2_tag;
            for (int r = 0; r < NUM_AXES; r++) begin
                r3_c0[r] <= C0_W'(r2_p0[r][0]) + C0_W'(r2_p0[r][1]) + C0_W'(r2_p0[r][2])
                          + (C0_W'(r2_sh[r]) <<< COEF_FRAC);
                r3_es[r] <= ES_W'(r2_e[r][0]) + ES_W'(r2_e[r][1]) + ES_W'(r2_e[r][2]);
                for (int c = 0; c < NUM_AXES; c++) begin
                    r3_e[r][c] <= r2_e[r][c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_tag <= r3_tag;
            for (int p = 0; p < NUM_PLANES; p++) begin
                for (int r = 0; r < NUM_AXES; r++) begin
                    r4_nc[p][r] <= NC_W'(w_norm[p][r]) * NC_W'(r3_c0[r]);
                    for (int c = 0; c < NUM_AXES; c++) begin
                        r4_ne[p][c][r] <= NE_W'(w_norm[p][r]) * NE_W'(r3_e[r][c]);
                    end
                end
            end
            for (int r = 0; r < NUM_AXES; r++) begin
                r4_d[r] <= (D_W'(w_cam[r]) <<< CAM_SHIFT) - (D_W'(r3_c0[r]) <<< 1)
                         - D_W'(r3_es[r]);
            end
        end
    end

    always_comb begin
        logic [D_W-1:0] mag;
        logic [D_W:0]   rnd;
        for (int r = 0; r < NUM_AXES; r++) begin
            mag    = r4_d[r][D_W-1] ? $unsigned(-r4_d[r]) : $unsigned(r4_d[r]);
            rnd    = {1'b0, mag} + (D_W + 1)'(ROUND_HALF);
            w_a[r] = rnd[ROUND_SHIFT +: A_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_tag <= r4_tag;
            for (int p = 0; p < NUM_PLANES; p++) begin
                r5_dot[p] <= DOT_W'(r4_nc[p][0]) + DOT_W'(r4_nc[p][1]) + DOT_W'(r4_nc[p][2]);
                for (int c = 0; c < NUM_AXES; c++) begin
                    r5_de[p][c] <= DE_W'(r4_ne[p][c][0]) + DE_W'(r4_ne[p][c][1])
                                 + DE_W'(r4_ne[p][c][2]);
                end
            end
            for (int r = 0; r < NUM_AXES; r++) begin
                r5_a[r] <= w_a[r];
            end
        end
    end

    // The nearest corner to each plane takes the negative edge terms only.
    always_comb begin
        logic signed [MIN_W-1:0] acc;
        for (int p = 0; p < NUM_PLANES; p++) begin
            acc = MIN_W'(r5_dot[p]);
            for (int c = 0; c < NUM_AXES; c++) begin
                if (r5_de[p][c][DE_W-1]) begin
                    acc = acc + MIN_W'(r5_de[p][c]);
                end
            end
            w_min[p] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_tag <= r5_tag;
            for (int p = 0; p < NUM_PLANES; p++) begin
                r6_min[p] <= w_min[p];
            end
            for (int r = 0; r < NUM_AXES; r++) begin
                r6_sq[r] <= SQ_W'(r5_a[r]) * SQ_W'(r5_a[r]);
            end
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            w_out[p] = r6_min[p] > (MIN_W'(w_offs[p]) <<< OFF_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_tag    <= r6_tag;
            r7_culled <= r_cull_en & (|w_out);
            r7_sum    <= SUM_W'(r6_sq[0]) + SUM_W'(r6_sq[1]) + SUM_W'(r6_sq[2]);
        end
    end

    assign w_sq_ctl_in = '{valid: r7_vld, culled: r7_culled};

    afc_isqrt #(
        .TAG_BITS (TAG_BITS)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_ctl   (w_sq_ctl_in),
        .i_tag   (r7_tag),
        .i_sum   (r7_sum),
        .o_ctl   (w_last_ctl),
        .o_tag   (w_last_tag),
        .o_dist  (w_last_dist)
    );

    assign w_take = r_out_vld & !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_last_ctl.valid) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out_tag  <= r_skid_tag;
                r_out_vis  <= r_skid_vis;
                r_out_dist <= r_skid_dist;
            end
        end else if (w_last_ctl.valid) begin
            if (!r_out_vld || w_take) begin
                r_out_tag  <= w_last_tag;
                r_out_vis  <= !w_last_ctl.culled;
                r_out_dist <= w_last_dist;
            end else begin
                r_skid_tag  <= w_last_tag;
                r_skid_vis  <= !w_last_ctl.culled;
                r_skid_dist <= w_last_dist;
            end
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_result_tag      = r_out_tag;
    assign o_visible         = r_out_vis;
    assign o_camera_distance = r_out_dist;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry occupied while output register is empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && i_out_stall && w_last_ctl.valid))
        else $error("skid entry filled without a held output transaction");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !w_take |=> r_skid_vld && $stable(r_skid_tag))
        else $error("skid entry lost before the output drained");

    a_culled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_visible |-> o_camera_distance == '0)
        else $error("culled transaction carries a nonzero distance");
`endif

endmodule

/* sv/afc_isqrt.sv */
module afc_isqrt #(
    parameter int TAG_BITS = afc_pkg::TAG_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  afc_pkg::t_item_ctl         i_ctl,
    input  logic [TAG_BITS-1:0]        i_tag,
    input  logic [afc_pkg::SUM_W-1:0]  i_sum,
    output afc_pkg::t_item_ctl         o_ctl,
    output logic [TAG_BITS-1:0]        o_tag,
    output logic [afc_pkg::DIST_W-1:0] o_dist
);
    import afc_pkg::*;

    t_item_ctl           r_ctl  [ROOT_W];
    logic [TAG_BITS-1:0] r_tag  [ROOT_W];
    logic                r_sat  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [REM_W-1:0]    r_rem  [ROOT_W-1];
    logic [RAD_W-1:0]    r_rad  [ROOT_W-1];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_step
        t_item_ctl           w_ctl;
        logic [TAG_BITS-1:0] w_tag;
        logic                w_sat;
        logic [ROOT_W-1:0]   w_root;
        logic [REM_W-1:0]    w_rem;
        logic [RAD_W-1:0]    w_rad;
        logic [REM_W+1:0]    w_cur;
        logic [REM_W+1:0]    w_trial;
        logic [REM_W+1:0]    w_dif;
        logic                w_ge;

        if (j == 0) begin : g_src
            assign w_ctl  = i_ctl;
            assign w_tag  = i_tag;
            assign w_sat  = |i_sum[SUM_W-1:RAD_W];
            assign w_root = '0;
            assign w_rem  = '0;
            assign w_rad  = i_sum[RAD_W-1:0];
        end else begin : g_src
            assign w_ctl  = r_ctl[j-1];
            assign w_tag  = r_tag[j-1];
            assign w_sat  = r_sat[j-1];
            assign w_root = r_root[j-1];
            assign w_rem  = r_rem[j-1];
            assign w_rad  = r_rad[j-1];
        end

        assign w_cur   = {w_rem, w_rad[RAD_W-1 -: 2]};
        assign w_trial = (REM_W + 2)'({w_root, 2'b01});
        assign w_ge    = (w_cur >= w_trial);
        assign w_dif   = w_cur - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j] <= '0;
            end else if (i_en) begin
                r_ctl[j] <= w_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[j]  <= w_tag;
                r_sat[j]  <= w_sat;
                r_root[j] <= {w_root[ROOT_W-2:0], w_ge};
            end
        end

        if (j < ROOT_W - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_ge ? w_dif[REM_W-1:0] : w_cur[REM_W-1:0];
                    r_rad[j] <= w_rad << 2;
                end
            end
        end
    end

    assign o_ctl  = r_ctl[ROOT_W-1];
    assign o_tag  = r_tag[ROOT_W-1];
    assign o_dist = r_ctl[ROOT_W-1].culled ? '0 :
                    r_sat[ROOT_W-1]        ? '1 : r_root[ROOT_W-1];

endmodule

/* verif/aabb_frustum_cull_checker.sv */
module aabb_frustum_cull_checker #(
    parameter int TAG_BITS = afc_pkg::TAG_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [afc_pkg::PADDR_W-1:0]         paddr,
    input  logic [afc_pkg::PDATA_W-1:0]         pwdata,
    input  logic                                pready,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic [TAG_BITS-1:0]                 i_object_tag,
    input  logic [afc_pkg::ROW_W-1:0]           i_matrix_row_x,
    input  logic [afc_pkg::ROW_W-1:0]           i_matrix_row_y,
    input  logic [afc_pkg::ROW_W-1:0]           i_matrix_row_z,
    input  logic [afc_pkg::COORD_W-1:0]         i_shift_x,
    input  logic [afc_pkg::COORD_W-1:0]         i_shift_y,
    input  logic [afc_pkg::COORD_W-1:0]         i_shift_z,
    input  logic [afc_pkg::BOX_W-1:0]           i_box_x,
    input  logic [afc_pkg::BOX_W-1:0]           i_box_y,
    input  logic [afc_pkg::BOX_W-1:0]           i_box_z,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [TAG_BITS-1:0]                 o_result_tag,
    input  logic                                o_visible,
    input  logic [afc_pkg::DIST_W-1:0]          o_camera_distance,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import afc_pkg::*;

    localparam longint unsigned DIST_SAT = (64'd1 << DIST_W) - 64'd1;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                visible;
        logic [DIST_W-1:0]   distance;
    } t_cull_result;

    logic [PDATA_W-1:0] plane_cfg [NUM_PLANES];
    logic [CAM_W-1:0]   camera_cfg;
    logic               cull_en_cfg;
    t_cull_result       expected_results [$];
    int                 fail_total = 0;
    int                 shown = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint sext_field(input logic [63:0] v, input int w);
        logic [63:0] t;
        t = v << (64 - w);
        return $signed(t) >>> (64 - w);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= x) root = cand;
        end
        return root;
    endfunction

    function automatic t_cull_result predict_cull(
        input logic [TAG_BITS-1:0] tag,
        input logic [ROW_W-1:0]    rx,
        input logic [ROW_W-1:0]    ry,
        input logic [ROW_W-1:0]    rz,
        input logic [COORD_W-1:0]  tx,
        input logic [COORD_W-1:0]  ty,
        input logic [COORD_W-1:0]  tz,
        input logic [BOX_W-1:0]    bx,
        input logic [BOX_W-1:0]    by,
        input logic [BOX_W-1:0]    bz
    );
        t_cull_result       res;
        logic [ROW_W-1:0]   rows [3];
        logic [COORD_W-1:0] shifts [3];
        logic [BOX_W-1:0]   boxes [3];
        longint             coef [9];
        longint             shv [3];
        longint             lo [3];
        longint             hi [3];
        longint             cam [3];
        longint             world [24];
        longint             nx, ny, nz, off, dot, twice, diff, mag, pick;
        longint unsigned    sumsq, root;
        bit                 culled, all_out;
        rows[0]   = rx;
        rows[1]   = ry;
        rows[2]   = rz;
        shifts[0] = tx;
        shifts[1] = ty;
        shifts[2] = tz;
        boxes[0]  = bx;
        boxes[1]  = by;
        boxes[2]  = bz;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r*3+c] = sext_field(64'(rows[r]) >> (COEF_W * c), COEF_W);
            end
            shv[r] = sext_field(64'(shifts[r]), COORD_W);
            lo[r]  = sext_field(64'(boxes[r]), COORD_W);
            hi[r]  = sext_field(64'(boxes[r]) >> COORD_W, COORD_W);
            cam[r] = sext_field(64'(camera_cfg) >> (COORD_W * r), COORD_W);
        end
        for (int k = 0; k < 8; k++) begin
            for (int r = 0; r < 3; r++) begin
                world[k*3+r] = shv[r] * 16384;
                for (int c = 0; c < 3; c++) begin
                    pick = ((k >> c) & 1) ? hi[c] : lo[c];
                    world[k*3+r] += coef[r*3+c] * pick;
                end
            end
        end
        culled = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            nx  = sext_field(plane_cfg[p], NORM_W);
            ny  = sext_field(plane_cfg[p] >> NORM_W, NORM_W);
            nz  = sext_field(plane_cfg[p] >> (2 * NORM_W), NORM_W);
            off = sext_field(plane_cfg[p] >> (3 * NORM_W), OFFS_W) * 64'sd16777216;
            all_out = 1'b1;
            for (int k = 0; k < 8; k++) begin
                dot = nx * world[k*3] + ny * world[k*3+1] + nz * world[k*3+2];
                if (dot <= off) all_out = 1'b0;
            end
            if (all_out) culled = 1'b1;
        end
        if (!cull_en_cfg) culled = 1'b0;
        res.tag      = tag;
        res.visible  = !culled;
        res.distance = '0;
        if (!culled) begin
            sumsq = 0;
            for (int r = 0; r < 3; r++) begin
                twice = shv[r] * 32768;
                for (int c = 0; c < 3; c++) begin
                    twice += coef[r*3+c] * (lo[c] + hi[c]);
                end
                diff  = cam[r] * 32768 - twice;
                mag   = (diff < 0) ? -diff : diff;
                mag   = (mag + 16384) >>> 15;
                sumsq += mag * mag;
            end
            root = floor_sqrt(sumsq);
            if (root > DIST_SAT) root = DIST_SAT;
            res.distance = root[DIST_W-1:0];
        end
        return res;
    endfunction

    // A result is checked before the transaction of the same edge is queued, so it can
    // never be matched against its own input.
    always @(posedge i_clk) begin
        t_cull_result got;
        t_cull_result want;
        logic [REG_IDX_W-1:0] idx;
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) plane_cfg[p] = '0;
            camera_cfg  = '0;
            cull_en_cfg = 1'b1;
            expected_results.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.tag      = o_result_tag;
                got.visible  = o_visible;
                got.distance = o_camera_distance;
                if (expected_results.size() == 0) begin
                    fail_total++;
                    if (shown < MAX_SHOWN) begin
                        shown++;
                        $display("unexpected result: tag %h visible %b distance %0d",
                                 got.tag, got.visible, got.distance);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.tag !== want.tag || got.visible !== want.visible ||
                        got.distance !== want.distance) begin
                        fail_total++;
                        if (shown < MAX_SHOWN) begin
                            shown++;
                            $display("mismatch: expected tag/vis/dist %h/%b/%0d, got %h/%b/%0d",
                                     want.tag, want.visible, want.distance,
                                     got.tag, got.visible, got.distance);
                        end
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                idx = paddr[PADDR_W-1:3];
                if (idx < NUM_PLANES) begin
                    plane_cfg[idx] = pwdata;
                end else if (idx == REG_CAMERA) begin
                    camera_cfg = pwdata[CAM_W-1:0];
                end else if (idx == REG_CULL_EN) begin
                    cull_en_cfg = pwdata[0];
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_cull(i_object_tag, i_matrix_row_x,
                    i_matrix_row_y, i_matrix_row_z, i_shift_x, i_shift_y, i_shift_z,
                    i_box_x, i_box_y, i_box_z));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

/* verif/tb_aabb_frustum_cull_unit.sv */
module tb_aabb_frustum_cull_unit;
    import afc_pkg::*;

    localparam int TAG_W        = TAG_BITS_DEFAULT;
    localparam int UNIT         = 256;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 200;
    localparam int NOISE_PCT    = 20;
    localparam int COORD_MAX    = 1048575;
    localparam int COORD_MIN    = -1048576;

    typedef enum logic [REG_IDX_W-1:0] {
        PLANE_NEAR,
        PLANE_FAR,
        PLANE_LEFT,
        PLANE_RIGHT,
        PLANE_TOP,
        PLANE_BOTTOM
    } t_plane_idx;

    typedef struct packed {
        logic [TAG_W-1:0]              tag;
        logic [2:0][ROW_W-1:0]         rows;
        logic [2:0][COORD_W-1:0]       shifts;
        logic [2:0][BOX_W-1:0]         boxes;
    } t_cull_item;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [TAG_W-1:0]           i_object_tag;
    logic [ROW_W-1:0]           i_matrix_row_x;
    logic [ROW_W-1:0]           i_matrix_row_y;
    logic [ROW_W-1:0]           i_matrix_row_z;
    logic signed [COORD_W-1:0]  i_shift_x;
    logic signed [COORD_W-1:0]  i_shift_y;
    logic signed [COORD_W-1:0]  i_shift_z;
    logic [BOX_W-1:0]           i_box_x;
    logic [BOX_W-1:0]           i_box_y;
    logic [BOX_W-1:0]           i_box_z;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [TAG_W-1:0]           o_result_tag;
    logic                       o_visible;
    logic [DIST_W-1:0]          o_camera_distance;

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;

    aabb_frustum_cull_unit #(.TAG_BITS(TAG_W)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_object_tag(i_object_tag),
        .i_matrix_row_x(i_matrix_row_x), .i_matrix_row_y(i_matrix_row_y),
        .i_matrix_row_z(i_matrix_row_z),
        .i_shift_x(i_shift_x), .i_shift_y(i_shift_y), .i_shift_z(i_shift_z),
        .i_box_x(i_box_x), .i_box_y(i_box_y), .i_box_z(i_box_z),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_result_tag(o_result_tag), .o_visible(o_visible),
        .o_camera_distance(o_camera_distance)
    );

    aabb_frustum_cull_checker #(.TAG_BITS(TAG_W)) cull_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_object_tag(i_object_tag),
        .i_matrix_row_x(i_matrix_row_x), .i_matrix_row_y(i_matrix_row_y),
        .i_matrix_row_z(i_matrix_row_z),
        .i_shift_x(i_shift_x), .i_shift_y(i_shift_y), .i_shift_z(i_shift_z),
        .i_box_x(i_box_x), .i_box_y(i_box_y), .i_box_z(i_box_z),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_result_tag(o_result_tag), .o_visible(o_visible),
        .o_camera_distance(o_camera_distance),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic int rand_signed(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [PDATA_W-1:0] plane_word(input int nx, input int ny,
                                                      input int nz, input int off);
        t_plane pl;
        pl.nx     = nx[NORM_W-1:0];
        pl.ny     = ny[NORM_W-1:0];
        pl.nz     = nz[NORM_W-1:0];
        pl.offset = off[OFFS_W-1:0];
        return pl;
    endfunction

    function automatic logic [PDATA_W-1:0] camera_word(input int x, input int y, input int z);
        return {1'b0, z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
    endfunction

    function automatic t_cull_item diag_item(input logic [TAG_W-1:0] tag,
                                             input logic [COEF_W-1:0] d, input int sh,
                                             input int lo, input int hi);
        t_cull_item it;
        it.tag = tag;
        for (int r = 0; r < 3; r++) begin
            it.rows[r] = '0;
            it.rows[r][r*COEF_W +: COEF_W] = d;
            it.shifts[r] = sh[COORD_W-1:0];
            it.boxes[r]  = {hi[COORD_W-1:0], lo[COORD_W-1:0]};
        end
        return it;
    endfunction

    function automatic t_cull_item random_box(input int span, input int half_max);
        t_cull_item it;
        int coef, ctr, sz, lo, hi, tmp, sh;
        it.tag = TAG_W'($urandom);
        if ($urandom_range(99) < NOISE_PCT) begin
            for (int r = 0; r < 3; r++) begin
                it.rows[r]   = ROW_W'({$urandom, $urandom});
                it.shifts[r] = COORD_W'($urandom);
                it.boxes[r]  = BOX_W'({$urandom, $urandom});
            end
            return it;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef = ((r == c) ? 16384 : 0) + rand_signed(3000);
                if ($urandom_range(9) == 0) coef = $urandom;
                it.rows[r][c*COEF_W +: COEF_W] = coef[COEF_W-1:0];
            end
            sh  = rand_signed(span);
            sz  = $urandom_range(0, half_max);
            ctr = rand_signed(half_max);
            lo  = ctr - sz;
            hi  = ctr + sz;
            if ($urandom_range(19) == 0) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            it.shifts[r] = sh[COORD_W-1:0];
            it.boxes[r]  = {hi[COORD_W-1:0], lo[COORD_W-1:0]};
        end
        return it;
    endfunction

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_cull(input t_cull_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_object_tag   <= it.tag;
        i_matrix_row_x <= it.rows[0];
        i_matrix_row_y <= it.rows[1];
        i_matrix_row_z <= it.rows[2];
        i_shift_x      <= it.shifts[0];
        i_shift_y      <= it.shifts[1];
        i_shift_z      <= it.shifts[2];
        i_box_x        <= it.boxes[0];
        i_box_y        <= it.boxes[1];
        i_box_z        <= it.boxes[2];
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int span, input int half_max,
                              input int hold_at);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_req = 1'b1;
            send_cull(random_box(span, half_max));
        end
    endtask

    task automatic set_box_frustum(input int half);
        apb_write(PLANE_NEAR,   plane_word(0, 0, -1024, half));
        apb_write(PLANE_FAR,    plane_word(0, 0, 1024, half));
        apb_write(PLANE_LEFT,   plane_word(-1024, 0, 0, half));
        apb_write(PLANE_RIGHT,  plane_word(1024, 0, 0, half));
        apb_write(PLANE_TOP,    plane_word(0, 1024, 0, half));
        apb_write(PLANE_BOTTOM, plane_word(0, -1024, 0, half));
    endtask

    task automatic directed_reset_items();
        t_cull_item it;
        it = '0;
        send_cull(it);
        it = '1;
        send_cull(it);
        send_cull(diag_item(16'h0001, 18'd16384, 0, -10 * UNIT, 10 * UNIT));
        send_cull(diag_item(16'hFFFF, 18'd16384, COORD_MAX, COORD_MAX, COORD_MAX));
        send_cull(diag_item(16'h0000, 18'd16384, COORD_MIN, COORD_MIN, COORD_MIN));
        send_cull(diag_item(16'h1234, 18'h1FFFF, 0, COORD_MAX, COORD_MAX));
        send_cull(diag_item(16'h8000, 18'h20000, COORD_MIN, COORD_MIN, COORD_MAX));
        send_cull(diag_item(16'h00FF, 18'd16384, 1000 * UNIT, 20 * UNIT, -20 * UNIT));
        it = diag_item(16'h7FFF, 18'h20000, COORD_MAX, COORD_MIN, COORD_MAX);
        it.rows = {3{{3{18'h20000}}}};
        send_cull(it);
        it = {{183{2'b10}}, 1'b1};
        send_cull(it);
        send_cull(~it);
    endtask

    task automatic directed_plane_items(input int half);
        t_cull_item it;
        int v;
        for (int a = 0; a < 3; a++) begin
            for (int s = 0; s < 2; s++) begin
                it = diag_item(16'(16 + a * 2 + s), 18'd16384, 0, -10 * UNIT, 10 * UNIT);
                v  = (s == 0) ? half + 100 * UNIT : -(half + 100 * UNIT);
                it.shifts[a] = v[COORD_W-1:0];
                send_cull(it);
            end
        end
        it = diag_item(16'h0030, 18'd16384, 0, -10 * UNIT, 10 * UNIT);
        it.shifts[0] = half[COORD_W-1:0];
        send_cull(it);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        i_in_valid     <= 1'b0;
        i_object_tag   <= '0;
        i_matrix_row_x <= '0;
        i_matrix_row_y <= '0;
        i_matrix_row_z <= '0;
        i_shift_x      <= '0;
        i_shift_y      <= '0;
        i_shift_z      <= '0;
        i_box_x        <= '0;
        i_box_y        <= '0;
        i_box_z        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_reset_items();
        drain();

        set_box_frustum(1000 * UNIT);
        apb_write(REG_CAMERA, camera_word(0, 0, 0));
        apb_write(REG_CULL_EN, 64'd1);
        directed_plane_items(1000 * UNIT);
        run_random(280, 1500 * UNIT, 60 * UNIT, 120);
        drain();

        set_box_frustum(200 * UNIT);
        apb_write(REG_CAMERA, camera_word(rand_signed(500 * UNIT), rand_signed(500 * UNIT),
                                          rand_signed(500 * UNIT)));
        idle_pct = 61;
        run_random(280, 400 * UNIT, 40 * UNIT, -1);
        drain();

        for (int p = PLANE_NEAR; p < PLANE_BOTTOM; p++) begin
            if ($urandom_range(1) == 0) begin
                apb_write(REG_IDX_W'(p), plane_word(rand_signed(1024), rand_signed(1024),
                                                    rand_signed(1024),
                                                    rand_signed(2000 * UNIT)));
            end else begin
                apb_write(REG_IDX_W'(p), {$urandom, $urandom});
            end
        end
        apb_write(PLANE_BOTTOM, '1);
        apb_write(REG_CAMERA, {$urandom, $urandom});
        idle_pct  = 0;
        stall_pct = 61;
        run_random(280, 1000 * UNIT, 200 * UNIT, -1);
        drain();

        apb_write(PLANE_NEAR,   plane_word(2047, 2047, 2047, -(2 ** 27)));
        apb_write(PLANE_FAR,    plane_word(2047, 2047, 2047, -(2 ** 27)));
        apb_write(PLANE_LEFT,   plane_word(2047, 2047, 2047, -(2 ** 27)));
        apb_write(PLANE_RIGHT,  plane_word(-2048, -2048, -2048, 2 ** 27 - 1));
        apb_write(PLANE_TOP,    plane_word(-2048, -2048, -2048, 2 ** 27 - 1));
        apb_write(PLANE_BOTTOM, plane_word(-2048, -2048, -2048, 2 ** 27 - 1));
        apb_write(REG_CAMERA, camera_word(COORD_MIN, COORD_MIN, COORD_MIN));
        apb_write(REG_CULL_EN, 64'd0);
        idle_pct  = 12;
        stall_pct = 12;
        run_random(180, 2000 * UNIT, 300 * UNIT, -1);
        drain();

        apb_write(REG_CULL_EN, 64'd1);
        apb_write(REG_CAMERA, camera_word(COORD_MAX, COORD_MAX, COORD_MAX));
        run_random(180, 2000 * UNIT, 300 * UNIT, -1);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/afc_pkg.sv
sv/afc_isqrt.sv
sv/aabb_frustum_cull_unit.sv
verif/aabb_frustum_cull_checker.sv
verif/tb_aabb_frustum_cull_unit.sv
